>>> hw/rtl/lkvc_pkg.sv
// Shared types and constants for the LRU key/value cache.
// Used by lkvc_cell and lru_key_value_cache; depends on nothing else.
package lkvc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam int MAX_ENTRIES_DEFAULT = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    // strobes broadcast from the sequencer to every cell
    typedef struct packed {
        logic match_en;   // register key compare and LRU compare
        logic update_en;  // apply the operation to the row
        logic is_put;
        logic hit;        // some cell matched the key
        logic evict;      // put miss replaces the least recent entry
    } lkvc_ctl_t;

    // hit and read data rippling down the row
    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] value;
    } lkvc_link_t;

    // per-cell status for checking
    typedef struct packed {
        logic matched;
        logic valid;
    } lkvc_stat_t;

endpackage

>>> hw/rtl/lkvc_cell.sv
// One cache entry: key, value, valid bit and recency rank.
// Depends on lkvc_pkg; instantiated in a row by lru_key_value_cache.
module lkvc_cell #(
    parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEFAULT,
    parameter int INDEX       = 0
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  lkvc_pkg::lkvc_ctl_t                    ctl,
    input  logic [lkvc_pkg::KEY_W-1:0]             req_key,
    input  logic [lkvc_pkg::VAL_W-1:0]             req_value,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0]       count,
    input  logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] lru_rank,
    input  logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] hit_rank,
    input  lkvc_pkg::lkvc_link_t                   link_in,
    input  logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] rank_in,
    output lkvc_pkg::lkvc_link_t                   link_out,
    output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] rank_out,
    output lkvc_pkg::lkvc_stat_t                   stat
);

    localparam int RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] SlotIdx = CW'(INDEX);

    logic [lkvc_pkg::KEY_W-1:0] key_reg;
    logic [lkvc_pkg::VAL_W-1:0] value_reg;
    logic                       valid_reg;
    logic [RW-1:0]              rank_reg;
    logic                       match_reg;
    logic                       lru_reg;

    logic target;
    logic touched;
    logic age;

    // put miss: either the least recent entry or the first free slot
    // (slots fill from zero upwards and are never freed)
    assign target  = ctl.is_put && !ctl.hit && (ctl.evict ? lru_reg : (SlotIdx == count));
    assign touched = (ctl.hit && match_reg) || target;
    assign age     = valid_reg && !touched &&
                     ((ctl.hit && (rank_reg < hit_rank)) || (!ctl.hit && ctl.is_put));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
            match_reg <= 1'b0;
            lru_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.match_en)
            begin
                match_reg <= valid_reg && (key_reg == req_key);
                lru_reg   <= valid_reg && (rank_reg == lru_rank);
            end
            if (ctl.update_en)
            begin
                if (touched)
                    rank_reg <= '0;
                else if (age)
                    rank_reg <= rank_reg + RW'(1);
                if (target)
                    valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.update_en)
        begin
            if (target)
                key_reg <= req_key;
            if (target || (ctl.is_put && ctl.hit && match_reg))
                value_reg <= req_value;
        end
    end

    assign link_out.hit   = link_in.hit | match_reg;
    assign link_out.value = link_in.value | (match_reg ? value_reg : '0);
    assign rank_out       = rank_in | (match_reg ? rank_reg : '0);

    assign stat.matched = match_reg;
    assign stat.valid   = valid_reg;

endmodule

>>> hw/rtl/lru_key_value_cache.sv
// Top level of the LRU key/value cache: sequencer, capacity register, result register.
// Depends on lkvc_pkg and lkvc_cell.
//
// Fully associative key/value store, least-recently-used replacement.
// Request channel (in_valid/in_ready): func (get or put), lookup_key, write_value.
// Result channel (out_valid/out_ready): found, read_value; one result beat per
// request beat, in order. read_value is the stored value on a get hit, else zero.
// Config channel (cfg_valid/cfg_ready/cfg_data): capacity_in_use; the user must write
// it only while idle, which the block does not enforce; always ready. Zero acts as
// one, values above MAX_ENTRIES as MAX_ENTRIES. Timing: a request passes a match
// state, in which every cell compares its key and recency rank in parallel, then an
// update state, in which the row updates and the result is registered. A new request
// can be taken in the update cycle of the one before. The hit/read-data ripple through
// the row of MAX_ENTRIES cells sets the update path.
// Reset empties the cache and sets capacity to 16; no clearing pass is needed.
// If the result register is still held by a stalled receiver, the update cycle
// waits, and no new request is taken until it goes ahead.
module lru_key_value_cache #(
    parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              func,
    input  logic signed [lkvc_pkg::KEY_W-1:0] lookup_key,
    input  logic signed [lkvc_pkg::VAL_W-1:0] write_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              found,
    output logic signed [lkvc_pkg::VAL_W-1:0] read_value,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lkvc_pkg::CAP_W-1:0]        cfg_data
);

    localparam int RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = (CW > lkvc_pkg::CAP_W) ? CW : lkvc_pkg::CAP_W;
    localparam logic [EW-1:0] MaxE = EW'(MAX_ENTRIES);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MATCH  = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [lkvc_pkg::CAP_W-1:0]   cap_reg;
    logic [CW-1:0]                count_reg;
    logic                         put_reg;
    logic [lkvc_pkg::KEY_W-1:0]   key_reg;
    logic [lkvc_pkg::VAL_W-1:0]   wval_reg;
    logic                         out_valid_reg;
    logic                         found_reg;
    logic [lkvc_pkg::VAL_W-1:0]   rval_reg;

    logic                         out_free;
    logic                         in_acc;
    logic                         do_update;
    logic [EW-1:0]                cap_ext;
    logic [EW-1:0]                eff_cap;
    logic                         evict;
    logic [RW-1:0]                lru_rank;
    lkvc_pkg::lkvc_ctl_t          ctl;

    lkvc_pkg::lkvc_link_t         link [MAX_ENTRIES+1];
    logic [RW-1:0]                rank_link [MAX_ENTRIES+1];
    lkvc_pkg::lkvc_stat_t         stat [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]       match_vec;
    logic [MAX_ENTRIES-1:0]       valid_vec;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_UPDATE) && out_free);
    assign in_acc    = in_valid && in_ready;
    assign do_update = (state_reg == ST_UPDATE) && out_free;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cap_ext = EW'(cap_reg);
        if (cap_ext == '0)
            eff_cap = EW'(1);
        else if (cap_ext > MaxE)
            eff_cap = MaxE;
        else
            eff_cap = cap_ext;
    end

    assign evict    = EW'(count_reg) >= eff_cap;
    assign lru_rank = RW'(count_reg - CW'(1));

    assign ctl.match_en  = (state_reg == ST_MATCH);
    assign ctl.update_en = do_update;
    assign ctl.is_put    = put_reg;
    assign ctl.hit       = link[MAX_ENTRIES].hit;
    assign ctl.evict     = evict;

    assign link[0].hit    = 1'b0;
    assign link[0].value  = '0;
    assign rank_link[0]   = '0;

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        lkvc_cell #(
            .MAX_ENTRIES (MAX_ENTRIES),
            .INDEX       (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .req_key   (key_reg),
            .req_value (wval_reg),
            .count     (count_reg),
            .lru_rank  (lru_rank),
            .hit_rank  (rank_link[MAX_ENTRIES]),
            .link_in   (link[i]),
            .rank_in   (rank_link[i]),
            .link_out  (link[i+1]),
            .rank_out  (rank_link[i+1]),
            .stat      (stat[i])
        );
        assign match_vec[i] = stat[i].matched;
        assign valid_vec[i] = stat[i].valid;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                    state_next = ST_MATCH;
            end
            ST_MATCH:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (out_free)
                    state_next = in_acc ? ST_MATCH : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= lkvc_pkg::CAP_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
                cap_reg <= cfg_data;
            if (do_update && put_reg && !ctl.hit && !evict)
                count_reg <= count_reg + CW'(1);
            if (do_update)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            put_reg  <= func;
            key_reg  <= lookup_key;
            wval_reg <= write_value;
        end
        if (do_update)
        begin
            found_reg <= ctl.hit;
            rval_reg  <= (ctl.hit && (put_reg == lkvc_pkg::FUNC_GET)) ?
                         link[MAX_ENTRIES].value : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign read_value = rval_reg;

    // keys held in valid cells are unique
    a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("more than one cell matched the key");

    // cells fill from slot zero and are never freed
    a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("valid cells disagree with the fill count");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= MAX_ENTRIES)
        else $error("fill count above the number of cells");

    // a result beat only follows an update cycle
    a_out_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_UPDATE))
        else $error("result raised outside an update cycle");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for lru_key_value_cache: a directed table, then random phases.
// Keeps its own LRU predictor of the cache. Depends on lkvc_pkg and the RTL top level only.
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_SLOTS   = lkvc_pkg::MAX_ENTRIES_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;
    localparam int N_DIRECTED  = 24;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 80;

    typedef struct packed {
        logic                       found;
        logic [lkvc_pkg::VAL_W-1:0] value;
    } reply_t;

    // a row is either a request or a capacity write (capacity carried in data)
    typedef struct packed {
        bit                         is_cfg;
        logic                       op;
        logic [lkvc_pkg::KEY_W-1:0] key;
        logic [lkvc_pkg::VAL_W-1:0] data;
        bit                         typed;
        logic                       exp_found;
        logic [lkvc_pkg::VAL_W-1:0] exp_value;
    } step_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       func = lkvc_pkg::FUNC_GET;
    logic [lkvc_pkg::KEY_W-1:0] lookup_key = '0;
    logic [lkvc_pkg::VAL_W-1:0] write_value = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic                       found;
    logic [lkvc_pkg::VAL_W-1:0] read_value;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [lkvc_pkg::CAP_W-1:0] cfg_data = '0;

    // predictor state
    logic [lkvc_pkg::KEY_W-1:0] cached_key [MAX_SLOTS];
    logic [lkvc_pkg::VAL_W-1:0] cached_val [MAX_SLOTS];
    bit                         cached_vld [MAX_SLOTS];
    int unsigned                age_rank [MAX_SLOTS];
    int                         fill_count = 0;
    logic [lkvc_pkg::CAP_W-1:0] capacity_reg = lkvc_pkg::CAP_RESET;

    reply_t replies_due [$];

    bit calm = 1'b0;
    int faults = 0;
    int cycles = 0;
    int requests = 0;
    int hits = 0;
    int evictions = 0;
    int cap_writes = 0;

    step_row_t directed_steps [N_DIRECTED] = '{
        '{1'b0, lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{1'b0, lkvc_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1, 1'b0, 32'h0000_0000},
        '{1'b0, lkvc_pkg::FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
        '{1'b0, lkvc_pkg::FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{1'b0, lkvc_pkg::FUNC_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF},
        '{1'b0, lkvc_pkg::FUNC_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h8000_0000},
        // overwrite of a present key: found, no data
        '{1'b0, lkvc_pkg::FUNC_PUT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000},
        '{1'b0, lkvc_pkg::FUNC_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
        '{1'b0, lkvc_pkg::FUNC_PUT, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        // zero key holding zero: a hit must still say found
        '{1'b0, lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
        // capacity dropped below occupancy, nothing flushed
        '{1'b1, lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'd1,         1'b0, 1'b0, 32'h0000_0000},
        '{1'b0, lkvc_pkg::FUNC_PUT, 32'h1234_5678, 32'hA5A5_A5A5, 1'b1, 1'b0, 32'h0000_0000},
        '{1'b0, lkvc_pkg::FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{1'b0, lkvc_pkg::FUNC_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{1'b0, lkvc_pkg::FUNC_PUT, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0, 1'b0, 32'h0000_0000},
        '{1'b0, lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        // zero acts as one
        '{1'b1, lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'd0,         1'b0, 1'b0, 32'h0000_0000},
        '{1'b0, lkvc_pkg::FUNC_PUT, 32'hDEAD_BEEF, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{1'b0, lkvc_pkg::FUNC_GET, 32'h1234_5678, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        // above the row size acts as the row size
        '{1'b1, lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'd31,        1'b0, 1'b0, 32'h0000_0000},
        '{1'b0, lkvc_pkg::FUNC_PUT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0000_0000},
        '{1'b0, lkvc_pkg::FUNC_GET, 32'hAAAA_AAAA, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{1'b0, lkvc_pkg::FUNC_GET, 32'h5555_5555, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{1'b1, lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'd16,        1'b0, 1'b0, 32'h0000_0000}
    };

    lru_key_value_cache #(
        .MAX_ENTRIES (MAX_SLOTS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .lookup_key  (lookup_key),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .read_value  (read_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic int effective_cap(input logic [lkvc_pkg::CAP_W-1:0] c);
        if (c == 0)
            return 1;
        if (c > MAX_SLOTS)
            return MAX_SLOTS;
        return int'(c);
    endfunction

    // slot s becomes newest; valid slots newer than it age by one
    task automatic promote_slot(input int s);
        int unsigned old;
        old = cached_vld[s] ? age_rank[s] : 32'hFFFF_FFFF;
        for (int i = 0; i < MAX_SLOTS; i++)
            if (i != s && cached_vld[i] && age_rank[i] < old)
                age_rank[i] += 1;
        age_rank[s] = 0;
    endtask

    task automatic predict_access(input logic op, input logic [lkvc_pkg::KEY_W-1:0] k,
                                  input logic [lkvc_pkg::VAL_W-1:0] v, output reply_t r);
        int hit_slot;
        int target;
        int unsigned oldest;
        hit_slot = -1;
        for (int i = 0; i < MAX_SLOTS; i++)
            if (hit_slot < 0 && cached_vld[i] && cached_key[i] == k)
                hit_slot = i;
        r.found = (hit_slot >= 0);
        r.value = '0;
        if (r.found)
            hits++;
        if (op == lkvc_pkg::FUNC_GET)
        begin
            if (hit_slot >= 0)
            begin
                r.value = cached_val[hit_slot];
                promote_slot(hit_slot);
            end
        end
        else if (hit_slot >= 0)
        begin
            cached_val[hit_slot] = v;
            promote_slot(hit_slot);
        end
        else
        begin
            target = -1;
            if (fill_count >= effective_cap(capacity_reg))
            begin
                oldest = 0;
                for (int i = 0; i < MAX_SLOTS; i++)
                    if (cached_vld[i] && (target < 0 || age_rank[i] >= oldest))
                    begin
                        oldest = age_rank[i];
                        target = i;
                    end
                if (target >= 0)
                    evictions++;
            end
            if (target < 0)
            begin
                // lowest free slot
                for (int i = 0; i < MAX_SLOTS; i++)
                    if (target < 0 && !cached_vld[i])
                        target = i;
                promote_slot(target);
                cached_vld[target] = 1'b1;
                fill_count++;
            end
            else
                promote_slot(target);
            cached_key[target] = k;
            cached_val[target] = v;
        end
    endtask

    task automatic issue_request(input logic op, input logic [lkvc_pkg::KEY_W-1:0] k,
                                 input logic [lkvc_pkg::VAL_W-1:0] v, input bit typed,
                                 input reply_t typed_reply);
        reply_t r;
        while (!calm && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= op;
        lookup_key  <= k;
        write_value <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_access(op, k, v, r);
        replies_due.push_back(typed ? typed_reply : r);
        requests++;
    endtask

    task automatic set_capacity(input logic [lkvc_pkg::CAP_W-1:0] c);
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= c;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        capacity_reg = c;
        cap_writes++;
    endtask

    // mostly a small key pool so hits and evictions are common, some fresh keys
    task automatic run_phase(input logic [lkvc_pkg::CAP_W-1:0] cap, input int n,
                             input bit quiet);
        logic [lkvc_pkg::KEY_W-1:0] pool [24];
        int pool_n;
        logic [lkvc_pkg::KEY_W-1:0] k;
        reply_t none;
        none = '0;
        set_capacity(cap);
        calm = quiet;
        pool_n = effective_cap(cap) + $urandom_range(1, 6);
        for (int i = 0; i < pool_n; i++)
            pool[i] = $urandom;
        for (int i = 0; i < n; i++)
        begin
            k = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, pool_n - 1)] : $urandom;
            issue_request(logic'($urandom_range(0, 1)), k, $urandom, 1'b0, none);
        end
        calm = 1'b0;
    endtask

    always @(posedge clk)
        out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 20);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (replies_due.size() == 0)
            begin
                $display("%0t: result beat with none due: found %0b read_value %h",
                         $time, found, read_value);
                faults++;
            end
            else
            begin
                if (found !== replies_due[0].found)
                begin
                    $display("%0t: found expected %0b actual %0b",
                             $time, replies_due[0].found, found);
                    faults++;
                end
                if (read_value !== replies_due[0].value)
                begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, replies_due[0].value, read_value);
                    faults++;
                end
                void'(replies_due.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d results due", $time, replies_due.size());
            $display("FAIL lru_key_value_cache");
            $finish;
        end
    end

    initial
    begin
        logic [lkvc_pkg::CAP_W-1:0] phase_cap [N_PHASES];
        reply_t typed_reply;
        phase_cap = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd4, 5'd17, 5'd2, 5'd3};
        phase_cap[6] = lkvc_pkg::CAP_W'($urandom_range(2, 15));
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (directed_steps[i].is_cfg)
                set_capacity(directed_steps[i].data[lkvc_pkg::CAP_W-1:0]);
            else
            begin
                typed_reply.found = directed_steps[i].exp_found;
                typed_reply.value = directed_steps[i].exp_value;
                issue_request(directed_steps[i].op, directed_steps[i].key,
                              directed_steps[i].data, directed_steps[i].typed, typed_reply);
            end
        end

        // second phase runs with no idling on either side
        for (int p = 0; p < N_PHASES; p++)
            run_phase(phase_cap[p], PHASE_ITEMS, p == 1);

        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Covered %0d requests: %0d hits, %0d evictions, %0d capacity writes.",
                 requests, hits, evictions, cap_writes);
        if (faults == 0)
            $display("PASS lru_key_value_cache");
        else
            $display("FAIL lru_key_value_cache");
        $finish;
    end

endmodule

>>> lru_key_value_cache.f
hw/rtl/lkvc_pkg.sv
hw/rtl/lkvc_cell.sv
hw/rtl/lru_key_value_cache.sv
verif/testbench.sv
